// ===== sv/evhp_pkg.sv =====
// evhp_pkg: shared types, constants and helpers for the ethernet vlan header parser
// used by evhp_parse, ethernet_vlan_header_parser and evhp_checker; no dependencies
package evhp_pkg;

	// frame layout
	localparam int MAC_BYTES      = 6;
	localparam int HDR_BYTES      = 14;
	localparam int TAG_BYTES      = 4;
	localparam int TAG_OFF_W      = $clog2(TAG_BYTES);
	localparam int POS_W          = 5;
	localparam int TAG_CNT_W      = 2;
	localparam int DEFAULT_MAX_TAGS = 2;

	// byte positions within the untagged header
	localparam logic [POS_W-1:0] POS_SRC_FIRST = POS_W'(MAC_BYTES);
	localparam logic [POS_W-1:0] POS_TYPE_LO   = POS_W'(2 * MAC_BYTES);
	localparam logic [POS_W-1:0] POS_TYPE_HI   = POS_W'(2 * MAC_BYTES + 1);
	localparam logic [POS_W-1:0] POS_TAG_BASE  = POS_W'(HDR_BYTES);

	// offsets within a tag
	localparam logic [TAG_OFF_W-1:0] TAG_OFF_TCI  = TAG_OFF_W'(1);
	localparam logic [TAG_OFF_W-1:0] TAG_OFF_TYPE = TAG_OFF_W'(TAG_BYTES - 1);

	// type words
	localparam logic [15:0] LEN_LIMIT      = 16'd1500;
	localparam logic [15:0] ETH_TYPE_IPV4  = 16'h0800;
	localparam logic [15:0] ETH_TYPE_ARP   = 16'h0806;
	localparam logic [15:0] ETH_TYPE_IPV6  = 16'h86DD;

	// register defaults
	localparam logic [15:0] VLAN_TPID_RESET = 16'h8100;
	localparam logic [1:0]  TAG_LIMIT_RESET = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_VLAN_TPID = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TAG_LIMIT = 1'b1;
	localparam int CFG_DATA_W = 16;

	// output packing
	localparam int RES_BITS = 155;
	localparam int RES_W    = 160;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_TRUNCATED = 2'd2,
		ST_LENGTH    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		PROTO_IPV4  = 2'd0,
		PROTO_ARP   = 2'd1,
		PROTO_IPV6  = 2'd2,
		PROTO_OTHER = 2'd3
	} proto_t;

	typedef struct packed {
		logic [4:0]           header_bytes;
		status_t              status;
		proto_t               next_protocol;
		logic [15:0]          inner_tci;
		logic [15:0]          outer_tci;
		logic [TAG_CNT_W-1:0] tag_count;
		logic [15:0]          ether_type;
		logic [47:0]          src_mac;
		logic [47:0]          dst_mac;
	} hdr_result_t;

	// next protocol class of a type word
	function automatic proto_t classify(input logic [15:0] t);
		proto_t cls;
		case (t)
			ETH_TYPE_IPV4: cls = PROTO_IPV4;
			ETH_TYPE_ARP:  cls = PROTO_ARP;
			ETH_TYPE_IPV6: cls = PROTO_IPV6;
			default:       cls = PROTO_OTHER;
		endcase
		return cls;
	endfunction

endpackage

// ===== sv/evhp_parse.sv =====
// evhp_parse: per-frame header state and single-pass result logic for one byte
// depends on evhp_pkg
module evhp_parse #(
	parameter int MAX_TAGS = evhp_pkg::DEFAULT_MAX_TAGS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           data_byte,
	input  logic                 frame_end,
	input  logic [15:0]          vlan_tpid,
	input  logic [1:0]           tag_limit,
	output logic                 res_valid,
	output evhp_pkg::hdr_result_t res
);
	import evhp_pkg::*;

	localparam logic [TAG_CNT_W-1:0] MAX_TAGS_C = TAG_CNT_W'(MAX_TAGS);

	logic [POS_W-1:0]     pos_q;
	logic [47:0]          dst_q;
	logic [47:0]          src_q;
	logic [15:0]          word_q;
	logic [15:0]          tag_q [MAX_TAGS];
	logic [TAG_CNT_W-1:0] tags_q;
	logic                 done_q;
	logic [15:0]          type_q;

	logic                 active;
	logic [15:0]          word_n;
	logic [47:0]          dst_n;
	logic [47:0]          src_n;
	logic [15:0]          tag_n [MAX_TAGS];
	logic [TAG_CNT_W-1:0] tags_n;
	logic [15:0]          type_n;
	logic [POS_W-1:0]     pos_n;
	logic [TAG_OFF_W-1:0] tag_off;
	logic                 in_tags;
	logic                 tag_wr;
	logic                 tag_end;
	logic                 type_done;
	logic [TAG_CNT_W-1:0] lim;
	logic                 is_tag;
	logic                 emit_hdr;
	logic                 emit_trunc;
	status_t              status_c;

	// next frame state for the byte in hand
	always_comb begin
		active  = !done_q;
		word_n  = {word_q[7:0], data_byte};
		dst_n   = (pos_q < POS_SRC_FIRST) ? {dst_q[39:0], data_byte} : dst_q;
		src_n   = (pos_q >= POS_SRC_FIRST && pos_q < POS_TYPE_LO) ?
			{src_q[39:0], data_byte} : src_q;
		in_tags = pos_q >= POS_TAG_BASE;
		tag_off = TAG_OFF_W'(pos_q - POS_TAG_BASE);
		tag_wr  = in_tags && tag_off == TAG_OFF_TCI;
		tag_end = in_tags && tag_off == TAG_OFF_TYPE;
		type_done = active && (pos_q == POS_TYPE_HI || tag_end);
		tags_n  = (tag_end && tags_q != '1) ? tags_q + 1'b1 : tags_q;
		type_n  = type_done ? word_n : type_q;
		pos_n   = (pos_q != '1) ? pos_q + 1'b1 : pos_q;
		for (int i = 0; i < MAX_TAGS; i++) begin
			tag_n[i] = (tag_wr && tags_q == TAG_CNT_W'(i)) ? word_n : tag_q[i];
		end
	end

	// header decision and result fields
	always_comb begin
		lim        = (tag_limit < MAX_TAGS_C) ? tag_limit : MAX_TAGS_C;
		is_tag     = word_n == vlan_tpid;
		emit_hdr   = type_done && (!is_tag || tags_n >= lim);
		emit_trunc = active && !emit_hdr && frame_end;
		res_valid  = emit_hdr || emit_trunc;

		if (emit_trunc)
			status_c = ST_TRUNCATED;
		else if (is_tag)
			status_c = ST_OVERFLOW;
		else if (word_n <= LEN_LIMIT)
			status_c = ST_LENGTH;
		else
			status_c = ST_OK;

		res.dst_mac      = dst_n;
		res.src_mac      = src_n;
		res.ether_type   = type_n;
		res.tag_count    = tags_n;
		res.outer_tci    = '0;
		res.inner_tci    = '0;
		for (int i = 0; i < MAX_TAGS; i++) begin
			if (tags_n > TAG_CNT_W'(i)) begin
				if (i == 0)
					res.outer_tci = tag_n[i];
				else
					res.inner_tci = tag_n[i];
			end
		end
		res.status        = status_c;
		res.next_protocol = (status_c == ST_OVERFLOW || status_c == ST_TRUNCATED) ?
			PROTO_OTHER : classify(type_n);
		res.header_bytes  = pos_q + 1'b1;
	end

	// frame state, cleared by the end-of-frame byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			dst_q  <= '0;
			src_q  <= '0;
			word_q <= '0;
			tags_q <= '0;
			done_q <= 1'b0;
			type_q <= '0;
			for (int i = 0; i < MAX_TAGS; i++) tag_q[i] <= '0;
		end else if (step) begin
			if (frame_end) begin
				pos_q  <= '0;
				dst_q  <= '0;
				src_q  <= '0;
				word_q <= '0;
				tags_q <= '0;
				done_q <= 1'b0;
				type_q <= '0;
				for (int i = 0; i < MAX_TAGS; i++) tag_q[i] <= '0;
			end else if (active) begin
				pos_q  <= pos_n;
				dst_q  <= dst_n;
				src_q  <= src_n;
				word_q <= word_n;
				tags_q <= tags_n;
				done_q <= emit_hdr;
				type_q <= type_n;
				for (int i = 0; i < MAX_TAGS; i++) tag_q[i] <= tag_n[i];
			end
		end
	end

endmodule

// ===== sv/ethernet_vlan_header_parser.sv =====
// ethernet_vlan_header_parser: byte stream ethernet ii header parser with a vlan tag stack
// depends on evhp_pkg and evhp_parse
// a byte taken passes the input register and the parse stage into the result register
// throughput: one byte per cycle, set by the input register feeding the single parse stage
// but a waiting result stalls parsing; the input register still takes a byte if empty
// reset: arst_n clears both valid flags and the frame state, loads the register defaults
module ethernet_vlan_header_parser #(
	parameter int MAX_TAGS = evhp_pkg::DEFAULT_MAX_TAGS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [7:0]                        s_axis_tdata,  // data_byte
	input  logic                              s_axis_tlast,  // frame_end
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// dst_mac, src_mac, ether_type, tag_count, outer_tci, inner_tci,
	// next_protocol, status, header_bytes, zero fill
	output logic [evhp_pkg::RES_W-1:0]        m_axis_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [evhp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [evhp_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import evhp_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        advance;
	logic [15:0] vlan_tpid_q;
	logic [1:0]  tag_limit_q;
	logic        res_valid;
	hdr_result_t res;
	logic        out_valid_q;
	hdr_result_t out_q;

	// handshakes
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign cfg_ready     = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vlan_tpid_q <= VLAN_TPID_RESET;
			tag_limit_q <= TAG_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_VLAN_TPID: vlan_tpid_q <= cfg_data[15:0];
				CFG_TAG_LIMIT: tag_limit_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	evhp_parse #(
		.MAX_TAGS (MAX_TAGS)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.data_byte (byte_s1),
		.frame_end (last_s1),
		.vlan_tpid (vlan_tpid_q),
		.tag_limit (tag_limit_q),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) out_q <= res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(RES_W - RES_BITS)'(0), out_q};

endmodule

// ===== sv/evhp_checker.sv =====
// evhp_checker: port-level checks on the header parser results, bound to the top level
// depends on evhp_pkg and ethernet_vlan_header_parser
module evhp_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [evhp_pkg::RES_W-1:0]        m_axis_tdata
);
	import evhp_pkg::*;

	hdr_result_t r;
	assign r = hdr_result_t'(m_axis_tdata[RES_BITS-1:0]);

	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// a stalled result keeps its fields
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// overflow and truncation report no protocol class
	a_class: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (r.status == ST_OVERFLOW || r.status == ST_TRUNCATED)
		|-> r.next_protocol == PROTO_OTHER)
		else $error("protocol class given on a failed header");

	// settled header length follows the tag count
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (r.status == ST_OK || r.status == ST_LENGTH)
		|-> r.header_bytes == 5'(HDR_BYTES) + 5'({r.tag_count, 2'b00}))
		else $error("header length does not match tag count");

	// absent tags read as zero
	a_tci: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && r.tag_count < 2'd2 |-> r.inner_tci == '0 &&
		(r.tag_count != '0 || r.outer_tci == '0))
		else $error("tci reported for an absent tag");

endmodule

bind ethernet_vlan_header_parser evhp_checker u_evhp_checker (.*);

// ===== sim/ethernet_vlan_header_parser_test.sv =====
// ethernet_vlan_header_parser_test: self-checking bench for the byte stream vlan header parser
// holds a header predictor and result store in a small class; depends on evhp_pkg and the dut
`timescale 1ns / 1ps

module ethernet_vlan_header_parser_test;
	import evhp_pkg::*;

	// predicts the header result of each frame and checks the results that come out
	class header_ledger;
		logic [15:0] tpid;
		logic [1:0]  tag_limit;
		logic [4:0]  pos;
		logic [47:0] dst;
		logic [47:0] src;
		logic [15:0] word;
		logic [15:0] last_type;
		logic [15:0] tci [2];
		logic [1:0]  ntags;
		bit          settled;
		hdr_result_t headers_due [$];
		int          mismatches;

		function new();
			tpid       = VLAN_TPID_RESET;
			tag_limit  = TAG_LIMIT_RESET;
			mismatches = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			pos       = '0;
			dst       = '0;
			src       = '0;
			word      = '0;
			last_type = '0;
			tci[0]    = '0;
			tci[1]    = '0;
			ntags     = '0;
			settled   = 1'b0;
		endfunction

		// queue the header as it stands now
		function void push_header(status_t st, logic [4:0] hbytes);
			hdr_result_t h;
			h = '0;
			h.dst_mac      = dst;
			h.src_mac      = src;
			h.ether_type   = last_type;
			h.tag_count    = ntags;
			h.outer_tci    = (ntags >= 1) ? tci[0] : 16'h0000;
			h.inner_tci    = (ntags >= 2) ? tci[1] : 16'h0000;
			h.status       = st;
			h.header_bytes = hbytes;
			if (st == ST_OVERFLOW || st == ST_TRUNCATED) begin
				h.next_protocol = PROTO_OTHER;
			end else begin
				case (last_type)
					ETH_TYPE_IPV4: h.next_protocol = PROTO_IPV4;
					ETH_TYPE_ARP:  h.next_protocol = PROTO_ARP;
					ETH_TYPE_IPV6: h.next_protocol = PROTO_IPV6;
					default:       h.next_protocol = PROTO_OTHER;
				endcase
			end
			headers_due.push_back(h);
		endfunction

		// advance the frame state by one accepted byte
		function void take_byte(logic [7:0] b, bit fin);
			logic [4:0] p;
			logic [1:0] off;
			int         lim;
			bit         type_done;
			if (!settled) begin
				p         = pos;
				type_done = 1'b0;
				word      = {word[7:0], b};
				if (p < 6) begin
					dst = {dst[39:0], b};
				end else if (p < 12) begin
					src = {src[39:0], b};
				end else if (p == 13) begin
					type_done = 1'b1;
				end else if (p >= 14) begin
					off = 2'(p - 5'd14);
					if (off == 2'd1 && ntags < 2) begin
						tci[ntags] = word;
					end else if (off == 2'd3) begin
						if (ntags < 3) ntags++;
						type_done = 1'b1;
					end
				end
				// a complete type word either opens another tag or settles the header
				if (type_done) begin
					lim       = (tag_limit < DEFAULT_MAX_TAGS) ? tag_limit : DEFAULT_MAX_TAGS;
					last_type = word;
					if (word == tpid) begin
						if (ntags >= lim) begin
							push_header(ST_OVERFLOW, 5'(p + 1));
							settled = 1'b1;
						end
					end else begin
						push_header((word <= LEN_LIMIT) ? ST_LENGTH : ST_OK, 5'(p + 1));
						settled = 1'b1;
					end
				end
				if (!settled && fin) push_header(ST_TRUNCATED, 5'(p + 1));
				if (pos < 31) pos++;
			end
			if (fin) clear_frame();
		endfunction

		task flag(string field, logic [63:0] got, logic [63:0] want);
			$display("%0t: %s mismatch, got %h expected %h", $time, field, got, want);
			mismatches++;
		endtask

		// compare one result transaction with the oldest expected header
		task check_header(hdr_result_t got);
			hdr_result_t want;
			if (headers_due.size() == 0) begin
				flag("unexpected result", 64'(got.dst_mac), 64'h0);
			end else begin
				want = headers_due.pop_front();
				if (got.dst_mac !== want.dst_mac)
					flag("dst_mac", 64'(got.dst_mac), 64'(want.dst_mac));
				if (got.src_mac !== want.src_mac)
					flag("src_mac", 64'(got.src_mac), 64'(want.src_mac));
				if (got.ether_type !== want.ether_type)
					flag("ether_type", 64'(got.ether_type), 64'(want.ether_type));
				if (got.tag_count !== want.tag_count)
					flag("tag_count", 64'(got.tag_count), 64'(want.tag_count));
				if (got.outer_tci !== want.outer_tci)
					flag("outer_tci", 64'(got.outer_tci), 64'(want.outer_tci));
				if (got.inner_tci !== want.inner_tci)
					flag("inner_tci", 64'(got.inner_tci), 64'(want.inner_tci));
				if (got.next_protocol !== want.next_protocol)
					flag("next_protocol", 64'(got.next_protocol), 64'(want.next_protocol));
				if (got.status !== want.status)
					flag("status", 64'(got.status), 64'(want.status));
				if (got.header_bytes !== want.header_bytes)
					flag("header_bytes", 64'(got.header_bytes), 64'(want.header_bytes));
			end
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata = '0;
	logic                  s_axis_tlast = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [RES_W-1:0]      m_axis_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	header_ledger ledger = new();
	int           send_idle = 0;
	int           recv_idle = 0;
	int           bytes_sent = 0;

	ethernet_vlan_header_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// clock
	initial begin
		forever #4 clk = ~clk;
	end

	// receiver: random stalls, check every accepted result
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			ledger.check_header(hdr_result_t'(m_axis_tdata[RES_BITS-1:0]));
		m_axis_tready <= ($urandom_range(99) >= recv_idle);
	end

	// one byte transaction on the input stream, with random gaps before it
	task automatic send_byte(logic [7:0] b, bit fin);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= fin;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		ledger.take_byte(b, fin);
		bytes_sent++;
	endtask

	task automatic send_frame(logic [7:0] fb [$]);
		foreach (fb[i]) send_byte(fb[i], i == fb.size() - 1);
	endtask

	// hold the sender until every expected header is out and the pipeline is empty
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (ledger.headers_due.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_VLAN_TPID) ledger.tpid = value;
		else ledger.tag_limit = value[1:0];
	endtask

	// type word mix: known protocols, the tag marker, length values and anything else
	function automatic logic [15:0] pick_type();
		case ($urandom_range(7))
			0:       return ETH_TYPE_IPV4;
			1:       return ETH_TYPE_ARP;
			2:       return ETH_TYPE_IPV6;
			3:       return ledger.tpid;
			4:       return 16'($urandom_range(LEN_LIMIT));
			5:       return LEN_LIMIT;
			6:       return LEN_LIMIT + 16'd1;
			default: return 16'($urandom);
		endcase
	endfunction

	// mostly well-formed frames with random tags, some cut short, some plain noise
	task automatic send_random_frame();
		logic [7:0]  fb [$];
		logic [15:0] t;
		int          kind;
		kind = $urandom_range(99);
		repeat (12) fb.push_back(8'($urandom));
		repeat ($urandom_range(3)) begin
			fb.push_back(ledger.tpid[15:8]);
			fb.push_back(ledger.tpid[7:0]);
			fb.push_back(8'($urandom));
			fb.push_back(8'($urandom));
		end
		t = pick_type();
		fb.push_back(t[15:8]);
		fb.push_back(t[7:0]);
		repeat ($urandom_range(5)) fb.push_back(8'($urandom));
		if (kind >= 90) begin
			fb.delete();
			repeat ($urandom_range(1, 24)) fb.push_back(8'($urandom));
		end else if (kind >= 75) begin
			kind = $urandom_range(1, fb.size());
			while (fb.size() > kind) void'(fb.pop_back());
		end
		send_frame(fb);
	endtask

	// stimulus
	initial begin
		logic [7:0]  fb [$];
		logic [15:0] tpid_pick;
		int          blk;
		int          stop_at;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// length frame with zero and all-ones macs and a byte after the header
		repeat (6) fb.push_back(8'h00);
		repeat (6) fb.push_back(8'hFF);
		fb.push_back(8'h05);
		fb.push_back(8'hDC);
		fb.push_back(8'hA5);
		send_frame(fb);
		// single byte frame, truncated at once
		fb.delete();
		fb.push_back(8'hFF);
		send_frame(fb);
		// tag limit zero: the first tag marker overflows
		write_reg(CFG_TAG_LIMIT, 16'd0);
		fb.delete();
		repeat (12) fb.push_back(8'h5A);
		fb.push_back(8'h81);
		fb.push_back(8'h00);
		send_frame(fb);

		// three idling phases, three register settings in each
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 7 : (ph == 1) ? 58 : 0;
			recv_idle = (ph == 0) ? 58 : (ph == 1) ? 7 : 0;
			for (int k = 0; k < 3; k++) begin
				blk = 3 * ph + k;
				case (blk % 5)
					0:       tpid_pick = 16'h8100;
					1:       tpid_pick = 16'h88A8;
					2:       tpid_pick = 16'h0000;
					3:       tpid_pick = 16'hFFFF;
					default: tpid_pick = 16'($urandom);
				endcase
				write_reg(CFG_VLAN_TPID, tpid_pick);
				write_reg(CFG_TAG_LIMIT, 16'(blk % 4));
				stop_at = bytes_sent + 170;
				while (bytes_sent < stop_at) send_random_frame();
			end
		end

		drain();
		if (ledger.mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== ethernet_vlan_header_parser.f =====
sv/evhp_pkg.sv
sv/evhp_parse.sv
sv/ethernet_vlan_header_parser.sv
sv/evhp_checker.sv
sim/ethernet_vlan_header_parser_test.sv
